// ===== hw/rtl/qra_pkg.sv =====
package qra_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_SQR,
    ST_NORM,
    ST_NEWT,
    ST_SCALE,
    ST_FIN
  } state_t;

  localparam logic OP_ROTATE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  localparam logic signed [17:0] QONE = 18'sh10000;
  localparam logic signed [17:0] QMIN = -18'sh20000;
  localparam logic signed [17:0] QMAX = 18'sh1ffff;

  localparam logic [42:0] X_HI = 43'h4000_0000;   // 2^30
  localparam logic [42:0] X_LO = 43'h1000_0000;   // 2^28
  localparam logic [33:0] THREE_Q30 = 34'h0_c000_0000;

  // multiplier operands and product
  localparam int MW = 35;
  localparam int PW = 2 * MW;

  typedef struct packed {
    logic [1:0] idx;
    logic       neg;
  } term_t;

  // left operand of term j of every component: w, x, y, z
  function automatic logic [1:0] a_index(input logic [1:0] j);
    logic [1:0] res;
    unique case (j)
      2'd0:    res = 2'd3;
      2'd1:    res = 2'd0;
      2'd2:    res = 2'd1;
      default: res = 2'd2;
    endcase
    return res;
  endfunction

  // right operand and sign of the Hamilton product, component c, term j
  function automatic term_t b_term(input logic [1:0] c, input logic [1:0] j);
    term_t res;
    unique case ({c, j})
      4'h0: res = '{2'd0, 1'b0};
      4'h1: res = '{2'd3, 1'b0};
      4'h2: res = '{2'd2, 1'b0};
      4'h3: res = '{2'd1, 1'b1};
      4'h4: res = '{2'd1, 1'b0};
      4'h5: res = '{2'd2, 1'b1};
      4'h6: res = '{2'd3, 1'b0};
      4'h7: res = '{2'd0, 1'b0};
      4'h8: res = '{2'd2, 1'b0};
      4'h9: res = '{2'd1, 1'b0};
      4'ha: res = '{2'd0, 1'b1};
      4'hb: res = '{2'd3, 1'b0};
      4'hc: res = '{2'd3, 1'b0};
      4'hd: res = '{2'd0, 1'b1};
      4'he: res = '{2'd1, 1'b1};
      default: res = '{2'd2, 1'b1};
    endcase
    return res;
  endfunction

  // 4/sqrt(i+0.5) seed, Q.16 before the shift up to Q.30
  function automatic logic [16:0] seed(input logic [3:0] i);
    logic [16:0] res;
    unique case (i)
      4'd4:    res = 17'd123576;
      4'd5:    res = 17'd111779;
      4'd6:    res = 17'd102821;
      4'd7:    res = 17'd95721;
      4'd8:    res = 17'd89915;
      4'd9:    res = 17'd85051;
      4'd10:   res = 17'd80899;
      4'd11:   res = 17'd77302;
      4'd12:   res = 17'd74146;
      4'd13:   res = 17'd71347;
      4'd14:   res = 17'd68842;
      4'd15:   res = 17'd66585;
      default: res = 17'd0;
    endcase
    return res;
  endfunction

endpackage

// ===== hw/rtl/qra_if.sv =====
interface qra_in_if;
  logic                valid;
  logic                ready;
  logic                opcode;
  logic signed [17:0]  in_x;
  logic signed [17:0]  in_y;
  logic signed [17:0]  in_z;
  logic signed [17:0]  in_w;
  modport source(output valid, opcode, in_x, in_y, in_z, in_w, input ready);
  modport sink(input valid, opcode, in_x, in_y, in_z, in_w, output ready);
endinterface

interface qra_out_if;
  logic                valid;
  logic                ready;
  logic signed [17:0]  out_x;
  logic signed [17:0]  out_y;
  logic signed [17:0]  out_z;
  logic signed [17:0]  out_w;
  logic                degenerate;
  modport source(output valid, out_x, out_y, out_z, out_w, degenerate, input ready);
  modport sink(input valid, out_x, out_y, out_z, out_w, degenerate, output ready);
endinterface

// ===== hw/rtl/qra_mul.sv =====
module qra_mul (
  input  logic                             clk,
  input  logic signed [qra_pkg::MW-1:0]    a,
  input  logic signed [qra_pkg::MW-1:0]    b,
  output logic signed [qra_pkg::PW-1:0]    p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== hw/rtl/quaternion_rotate_accumulate.sv =====
// channel  | dir | handshake     | payload
// item     | in  | valid/ready   | opcode, in_x, in_y, in_z, in_w
// result   | out | valid/ready   | out_x, out_y, out_z, out_w, degenerate
//
// One shared registered multiplier; each product is issued, then consumed from its register.
// Load goes straight to the final state. Rotate steps: Hamilton product, square sum, normalise,
// RSQRT_ITERS Newton iterations, scale, final; a zero square sum goes straight to final.
// rst (synchronous) restores the identity orientation and empties the result register.
// item is ready only in idle; a stalled result holds the block in its final state.
module quaternion_rotate_accumulate #(
  parameter int RSQRT_ITERS = 3
) (
  input  logic      clk,
  input  logic      rst,
  qra_in_if.sink    item,
  qra_out_if.source result
);

  localparam int IW = (RSQRT_ITERS > 1) ? $clog2(RSQRT_ITERS) : 1;

  qra_pkg::state_t state, state_next;

  logic [3:0]                   cnt;
  logic                         ph;
  logic [1:0]                   sub;
  logic [IW-1:0]                iter;
  logic signed [17:0]           ori [4];
  logic signed [17:0]           bq [4];
  logic signed [21:0]           r [4];
  logic signed [43:0]           acc;
  logic [42:0]                  nx;
  logic signed [4:0]            h;
  logic [31:0]                  y;
  logic [33:0]                  t;
  logic [31:0]                  v;
  logic                         deg;

  logic signed [qra_pkg::MW-1:0] mul_a, mul_b;
  logic signed [qra_pkg::PW-1:0] prod;

  logic                         in_acc;
  logic                         out_free;
  qra_pkg::term_t               term;
  logic signed [43:0]           acc_sum;
  logic signed [43:0]           rnd;
  logic [33:0]                  u;
  logic [5:0]                   sh;
  logic signed [54:0]           sc;
  logic signed [17:0]           sat;
  logic                         last_iter;

  qra_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  assign in_acc    = item.valid && item.ready;
  assign out_free  = !result.valid || result.ready;
  assign last_iter = (iter == IW'(RSQRT_ITERS - 1));
  assign term      = qra_pkg::b_term(cnt[3:2], cnt[1:0]);

  // datapath helpers
  always_comb begin
    acc_sum = acc + ((state == qra_pkg::ST_PROD && term.neg) ? -prod[43:0] : prod[43:0]);
    rnd     = (acc_sum + 44'sd32768) >>> 16;
    u       = prod[63:30];
    sh      = 6'(7'sd29 + 7'(h));
    sc      = (55'($signed(prod[53:0])) + (55'sd1 <<< (sh - 6'd1))) >>> sh;
    if (sc < 55'(qra_pkg::QMIN)) begin
      sat = qra_pkg::QMIN;
    end else if (sc > 55'(qra_pkg::QMAX)) begin
      sat = qra_pkg::QMAX;
    end else begin
      sat = sc[17:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      qra_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_next = (item.opcode == qra_pkg::OP_LOAD) ? qra_pkg::ST_FIN : qra_pkg::ST_PROD;
        end
      end
      qra_pkg::ST_PROD: begin
        if (ph && cnt == 4'hf) state_next = qra_pkg::ST_SQR;
      end
      qra_pkg::ST_SQR: begin
        if (ph && cnt[1:0] == 2'd3) begin
          state_next = (acc_sum == '0) ? qra_pkg::ST_FIN : qra_pkg::ST_NORM;
        end
      end
      qra_pkg::ST_NORM: begin
        if (nx < qra_pkg::X_HI && nx >= qra_pkg::X_LO) state_next = qra_pkg::ST_NEWT;
      end
      qra_pkg::ST_NEWT: begin
        if (ph && sub == 2'd2 && last_iter) state_next = qra_pkg::ST_SCALE;
      end
      qra_pkg::ST_SCALE: begin
        if (ph && cnt[1:0] == 2'd3) state_next = qra_pkg::ST_FIN;
      end
      qra_pkg::ST_FIN: begin
        if (out_free) state_next = qra_pkg::ST_IDLE;
      end
      default: state_next = qra_pkg::ST_IDLE;
    endcase
  end

  // outputs: handshake and multiplier operands
  always_comb begin
    item.ready = (state == qra_pkg::ST_IDLE);
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      qra_pkg::ST_PROD: begin
        mul_a = qra_pkg::MW'(ori[qra_pkg::a_index(cnt[1:0])]);
        mul_b = qra_pkg::MW'(bq[term.idx]);
      end
      qra_pkg::ST_SQR: begin
        mul_a = qra_pkg::MW'(r[cnt[1:0]]);
        mul_b = qra_pkg::MW'(r[cnt[1:0]]);
      end
      qra_pkg::ST_NEWT: begin
        priority case (sub)
          2'd0: begin
            mul_a = {3'b000, y};
            mul_b = {3'b000, y};
          end
          2'd1: begin
            mul_a = {5'b00000, nx[29:0]};
            mul_b = {1'b0, t};
          end
          default: begin
            mul_a = {3'b000, y};
            mul_b = {3'b000, v};
          end
        endcase
      end
      qra_pkg::ST_SCALE: begin
        mul_a = qra_pkg::MW'(r[cnt[1:0]]);
        mul_b = {3'b000, y};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= qra_pkg::ST_IDLE;
      result.valid  <= 1'b0;
      cnt           <= '0;
      ph            <= 1'b0;
      sub           <= '0;
      iter          <= '0;
      deg           <= 1'b0;
      ori[0]        <= '0;
      ori[1]        <= '0;
      ori[2]        <= '0;
      ori[3]        <= qra_pkg::QONE;
    end else begin
      state <= state_next;
      if (state == qra_pkg::ST_FIN && out_free) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        qra_pkg::ST_IDLE: begin
          if (in_acc) begin
            bq[0] <= item.in_x;
            bq[1] <= item.in_y;
            bq[2] <= item.in_z;
            bq[3] <= item.in_w;
            cnt   <= '0;
            ph    <= 1'b0;
            acc   <= '0;
            deg   <= 1'b0;
            if (item.opcode == qra_pkg::OP_LOAD) begin
              ori[0] <= item.in_x;
              ori[1] <= item.in_y;
              ori[2] <= item.in_z;
              ori[3] <= item.in_w;
            end
          end
        end
        qra_pkg::ST_PROD, qra_pkg::ST_SQR: begin
          ph <= !ph;
          if (ph) begin
            cnt <= cnt + 4'd1;
            if (cnt[1:0] == 2'd3) begin
              acc <= '0;
              if (state == qra_pkg::ST_PROD) begin
                r[cnt[3:2]] <= rnd[21:0];
              end
            end else begin
              acc <= acc_sum;
            end
            if (state == qra_pkg::ST_SQR && cnt[1:0] == 2'd3) begin
              nx <= acc_sum[42:0];
              h  <= '0;
              if (acc_sum == '0) begin
                ori[0] <= '0;
                ori[1] <= '0;
                ori[2] <= '0;
                ori[3] <= qra_pkg::QONE;
                deg    <= 1'b1;
              end
            end
          end
        end
        qra_pkg::ST_NORM: begin
          // two bits a step keeps the shift even
          if (nx >= qra_pkg::X_HI) begin
            nx <= nx >> 2;
            h  <= h + 5'sd1;
          end else if (nx < qra_pkg::X_LO) begin
            nx <= nx << 2;
            h  <= h - 5'sd1;
          end else begin
            y    <= {1'b0, qra_pkg::seed(nx[29:26]), 14'b0};
            iter <= '0;
            sub  <= '0;
            ph   <= 1'b0;
          end
        end
        qra_pkg::ST_NEWT: begin
          ph <= !ph;
          if (ph) begin
            priority case (sub)
              2'd0: begin
                t   <= prod[63:30];
                sub <= 2'd1;
              end
              2'd1: begin
                v   <= (u < qra_pkg::THREE_Q30) ? 32'(qra_pkg::THREE_Q30 - u) : '0;
                sub <= 2'd2;
              end
              default: begin
                y    <= prod[62:31];
                sub  <= 2'd0;
                iter <= iter + IW'(1);
                cnt  <= '0;
              end
            endcase
          end
        end
        qra_pkg::ST_SCALE: begin
          ph <= !ph;
          if (ph) begin
            ori[cnt[1:0]] <= sat;
            cnt           <= cnt + 4'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == qra_pkg::ST_FIN && out_free) begin
      result.out_x      <= ori[0];
      result.out_y      <= ori[1];
      result.out_z      <= ori[2];
      result.out_w      <= ori[3];
      result.degenerate <= deg;
    end
  end

`ifndef NO_ASSERTIONS
  a_deg_identity: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.degenerate |->
      result.out_x == '0 && result.out_y == '0 && result.out_z == '0 &&
      result.out_w == qra_pkg::QONE)
    else $error("degenerate beat without identity");

  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    state == qra_pkg::ST_NEWT |-> nx < qra_pkg::X_HI && nx >= qra_pkg::X_LO)
    else $error("Newton step on unnormalised value");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    state == qra_pkg::ST_SCALE |-> h >= -5'sd14 && h <= 5'sd7)
    else $error("scale shift out of range");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid && $stable(result.out_w))
    else $error("result dropped while stalled");
`endif

endmodule

// ===== tb/qra_checker.sv =====
module qra_checker
  import qra_pkg::*;
(
  input  logic clk,
  input  logic rst,
  qra_in_if    item,
  qra_out_if   result,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [17:0] z;
    logic signed [17:0] w;
    logic               degenerate;
  } orient_beat_t;

  localparam int NEWTON_STEPS = 3;

  // rsqrt seeds, Q.16; entries below 4 never used since x >= 2^28
  localparam longint unsigned RSQRT_SEED [16] = '{
    0, 0, 0, 0,
    123576, 111779, 102821, 95721, 89915, 85051, 80899, 77302,
    74146, 71347, 68842, 66585
  };

  logic signed [17:0] orient [4];
  orient_beat_t       expected_orients [$];

  function automatic longint round_half_up(input longint v, input int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [17:0] clamp18(input longint v);
    if (v < longint'(QMIN)) return QMIN;
    if (v > longint'(QMAX)) return QMAX;
    return v[17:0];
  endfunction

  // apply one beat to the tracked orientation, return the new orientation
  function automatic orient_beat_t next_orient(input logic op, input logic signed [17:0] b [4]);
    orient_beat_t      nb;
    longint            ax, ay, az, aw, bx, by, bz, bw;
    longint            r [4];
    longint unsigned   sq, xn, yv, t, u, v;
    int                msb, d, h;

    nb.degenerate = 1'b0;
    if (op == OP_LOAD) begin
      for (int i = 0; i < 4; i++) orient[i] = b[i];
    end else begin
      ax = orient[0]; ay = orient[1]; az = orient[2]; aw = orient[3];
      bx = b[0]; by = b[1]; bz = b[2]; bw = b[3];
      r[0] = round_half_up(aw * bx + ax * bw + ay * bz - az * by, 16);
      r[1] = round_half_up(aw * by - ax * bz + ay * bw + az * bx, 16);
      r[2] = round_half_up(aw * bz + ax * by - ay * bx + az * bw, 16);
      r[3] = round_half_up(aw * bw - ax * bx - ay * by - az * bz, 16);
      sq = 0;
      for (int i = 0; i < 4; i++) sq += longint'(r[i] * r[i]);
      if (sq == 0) begin
        orient[0] = '0; orient[1] = '0; orient[2] = '0; orient[3] = QONE;
        nb.degenerate = 1'b1;
      end else begin
        msb = 63;
        while (sq[msb] == 1'b0) msb--;
        // even shift into [2^28, 2^30)
        if (msb >= 28) begin
          d  = (msb - 28) & ~1;
          xn = sq >> d;
          h  = d / 2;
        end else begin
          d  = (28 - msb + 1) & ~1;
          xn = sq << d;
          h  = -(d / 2);
        end
        yv = RSQRT_SEED[(xn >> 26) & 15] << 14;
        for (int k = 0; k < NEWTON_STEPS; k++) begin
          t  = (yv * yv) >> 30;
          u  = (xn * t) >> 30;
          v  = longint'(3) << 30;
          v  = (u < v) ? (v - u) : 0;
          yv = (yv * v) >> 31;
        end
        for (int i = 0; i < 4; i++)
          orient[i] = clamp18(round_half_up(r[i] * longint'(yv), 29 + h));
      end
    end
    nb.x = orient[0]; nb.y = orient[1]; nb.z = orient[2]; nb.w = orient[3];
    return nb;
  endfunction

  task automatic report(input string field, input longint got, input longint want);
    $display("%0t: result %s got %0d expected %0d", $realtime, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    logic signed [17:0] b [4];
    orient_beat_t       want;
    if (rst) begin
      errors    = 0;
      pending   = 0;
      expected_orients.delete();
      orient[0] = '0; orient[1] = '0; orient[2] = '0; orient[3] = QONE;
    end else begin
      if (item.valid && item.ready) begin
        b[0] = item.in_x; b[1] = item.in_y; b[2] = item.in_z; b[3] = item.in_w;
        expected_orients.push_back(next_orient(item.opcode, b));
      end
      if (result.valid && result.ready) begin
        if (expected_orients.size() == 0) begin
          report("beat with nothing expected", 0, 0);
        end else begin
          want = expected_orients.pop_front();
          if (result.out_x !== want.x) report("out_x", result.out_x, want.x);
          if (result.out_y !== want.y) report("out_y", result.out_y, want.y);
          if (result.out_z !== want.z) report("out_z", result.out_z, want.z);
          if (result.out_w !== want.w) report("out_w", result.out_w, want.w);
          if (result.degenerate !== want.degenerate)
            report("degenerate", result.degenerate, want.degenerate);
        end
      end
      pending = expected_orients.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import qra_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  RANDOM_BEATS = 900;
  localparam int  CYCLE_LIMIT  = 2000000;
  localparam int  LONG_HOLD    = 400;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   gap_pct;
  int   stall_pct;
  bit   hold_go;
  int   cycles;

  qra_in_if  item ();
  qra_out_if result ();

  quaternion_rotate_accumulate #(.RSQRT_ITERS(3)) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item.sink),
    .result (result.source)
  );

  qra_checker chk (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .result  (result),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    result.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (rst) begin
        result.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else begin
        result.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_beat(input logic op, input logic signed [17:0] qx,
                           input logic signed [17:0] qy, input logic signed [17:0] qz,
                           input logic signed [17:0] qw);
    while ($urandom_range(99) < gap_pct) begin
      item.valid <= 1'b0;
      @(posedge clk);
    end
    item.valid  <= 1'b1;
    item.opcode <= op;
    item.in_x   <= qx;
    item.in_y   <= qy;
    item.in_z   <= qz;
    item.in_w   <= qw;
    do @(posedge clk); while (!item.ready);
  endtask

  function automatic logic signed [17:0] pick_component(input int mode);
    case (mode)
      0:       return 18'($signed($urandom_range(140000)) - 70000);
      1:       return 18'($urandom);
      default: return 18'($signed($urandom_range(4)) - 2);
    endcase
  endfunction

  task automatic random_beat();
    int   sel;
    int   mode;
    logic op;
    sel  = $urandom_range(99);
    op   = (sel < 15) ? OP_LOAD : OP_ROTATE;
    mode = (sel < 60) ? 0 : (sel < 85) ? 1 : 2;
    send_beat(op, pick_component(mode), pick_component(mode),
              pick_component(mode), pick_component(mode));
  endtask

  initial begin
    int per_phase;
    gap_pct      = 0;
    stall_pct    = 0;
    item.valid   = 1'b0;
    item.opcode  = OP_ROTATE;
    item.in_x    = '0;
    item.in_y    = '0;
    item.in_z    = '0;
    item.in_w    = '0;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: identity, zero products, extremes, tiny lengths
    send_beat(OP_ROTATE, 18'sd0, 18'sd0, 18'sd0, QONE);
    send_beat(OP_ROTATE, 18'sd0, 18'sd0, 18'sd0, 18'sd0);
    send_beat(OP_ROTATE, QONE, 18'sd0, 18'sd0, 18'sd0);
    send_beat(OP_ROTATE, 18'sd0, QONE, 18'sd0, 18'sd0);
    send_beat(OP_ROTATE, 18'sd0, 18'sd0, QONE, 18'sd0);
    send_beat(OP_LOAD, QMAX, QMAX, QMAX, QMAX);
    send_beat(OP_ROTATE, QMAX, QMAX, QMAX, QMAX);
    send_beat(OP_LOAD, QMIN, QMIN, QMIN, QMIN);
    send_beat(OP_ROTATE, QMIN, QMIN, QMIN, QMIN);
    send_beat(OP_LOAD, QMAX, QMIN, QMAX, QMIN);
    send_beat(OP_ROTATE, QMIN, QMAX, QMIN, QMAX);
    send_beat(OP_ROTATE, 18'sd1, 18'sd0, 18'sd0, 18'sd0);
    send_beat(OP_LOAD, 18'sd0, 18'sd0, 18'sd0, 18'sd0);
    send_beat(OP_ROTATE, 18'sd1000, -18'sd2000, 18'sd3000, QONE);
    send_beat(OP_LOAD, 18'sd1, 18'sd1, 18'sd1, 18'sd1);
    send_beat(OP_ROTATE, 18'sd0, 18'sd0, 18'sd0, QONE);
    send_beat(OP_LOAD, 18'sd200, 18'sd0, 18'sd0, 18'sd0);
    send_beat(OP_ROTATE, 18'sd0, 18'sd0, 18'sd0, 18'sd300);
    send_beat(OP_LOAD, 18'sd0, 18'sd0, 18'sd0, QONE);
    send_beat(OP_ROTATE, 18'sd46341, 18'sd0, 18'sd0, 18'sd46341);
    send_beat(OP_ROTATE, QMAX, 18'sd0, 18'sd0, 18'sd0);

    // hold the result side off while beats keep coming
    hold_go = 1'b1;

    per_phase = RANDOM_BEATS / 4;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 82; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 82; end
        default: begin gap_pct = 28; stall_pct = 28; end
      endcase
      for (int n = 0; n < per_phase; n++) random_beat();
    end
    item.valid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
